[design/button_press_classifier_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the button press classifier
// Concurrent checks in simulation, empty bodies in synthesis.
// ---------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property under the clock, skipped while reset is asserted
`define BPC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("button_press_classifier: assertion failed");
// Check that an antecedent implies a consequent in the same cycle
`define BPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("button_press_classifier: implication failed");
`else
`define BPC_ASSERT(lbl, clk, rstn, prop)
`define BPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

[design/bpc_pkg.sv]
// ---------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the button press classifier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned FlashW  = 3;
  localparam int unsigned EvtBits = 4;   // buttons visible in the event fields
  localparam int unsigned RawBits = 4;   // buttons carried by the input item

  localparam logic [CountW-1:0] CountMax     = '1;
  localparam logic [CountW-1:0] ThreshReset  = 16'd20;
  localparam logic [FlashW-1:0] FlashShort   = 3'd3;
  localparam logic [FlashW-1:0] FlashLong    = 3'd7;

  // Per-button mode, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_PRESSED = 4'b0010,
    MODE_LONG    = 4'b0100,
    MODE_HELD    = 4'b1000
  } bpc_mode_e;

  // Feedback kind reported per tick
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_LONG  = 2'd2
  } bpc_kind_e;

  // Events of one button in one tick
  typedef struct packed {
    logic short_fire;
    logic long_fire;
  } bpc_evt_t;

endpackage

`default_nettype wire

[design/button_press_classifier.sv]
// ---------------------------------------------------------------------------
// button_press_classifier
// Short and long press detector with UI flags and press feedback counter.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries one tick of raw button levels per transfer
//   (tdata[3:0], bit i = button i down). Master stream returns exactly one
//   result per tick: short and long event masks, the hide-UI and auto-zoom
//   flags, a render restart request, the feedback kind and the remaining
//   feedback hold count.
//   The long press threshold is written through cfg_we_i / cfg_wdata_i; the user must
//   write it only while the block is idle, which the block itself does not enforce; reset loads 20.
//   Path from input transfer to result valid: the input register takes the tick,
//   then the per-button update loads the result register once that is free.
//   Throughput is one tick per clock while the receiver takes results; the
//   two registers form a pipeline that keeps accepting while a result waits,
//   as long as a slot frees up.
//   When the receiver stalls, the result holds and tready drops once the
//   input register is also full.
//   Reset clears all button modes, hold counts, flags and the feedback count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "button_press_classifier_assert.svh"

module button_press_classifier #(
  parameter int unsigned NUM_BUTTONS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,   // long_press_ticks
  // input stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [3:0] buttons_raw, [7:4] zero
  // result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata   // [3:0] short_events, [7:4] long_events,
                                          // [8] ui_hidden, [9] auto_zoom_on,
                                          // [10] restart_render, [12:11] feedback_kind,
                                          // [15:13] feedback_hold
);

  logic [bpc_pkg::CountW-1:0]     thresh_q;
  logic                           in_valid_q;
  logic [bpc_pkg::RawBits-1:0]    in_raw_q;
  logic                           out_valid_q;
  logic                           adv;
  bpc_pkg::bpc_evt_t              evt [NUM_BUTTONS];
  logic [bpc_pkg::EvtBits-1:0]    shorts, longs;
  logic                           restart;
  bpc_pkg::bpc_kind_e             kind;
  logic                           hide_q, hide_d, auto_q, auto_d;
  logic [bpc_pkg::FlashW-1:0]     flash_q, flash_d;
  logic [15:0]                    out_data_q;

  // Pipeline control
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= bpc_pkg::ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_raw_q <= s_axis_tdata[bpc_pkg::RawBits-1:0];
    end
  end

  // Button lanes
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic down;
    if (i < bpc_pkg::RawBits) begin : g_raw
      assign down = in_raw_q[i];
    end else begin : g_none
      assign down = 1'b0;
    end
    bpc_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .down_i   (down),
      .thresh_i (thresh_q),
      .evt_o    (evt[i])
    );
  end

  // Gather the event masks visible at the outputs
  for (genvar b = 0; b < bpc_pkg::EvtBits; b++) begin : g_evt
    if (b < NUM_BUTTONS) begin : g_on
      assign shorts[b] = evt[b].short_fire;
      assign longs[b]  = evt[b].long_fire;
    end else begin : g_off
      assign shorts[b] = 1'b0;
      assign longs[b]  = 1'b0;
    end
  end

  assign restart = shorts[3] | longs[3];

  // Feedback kind: highest button with an event decides
  always_comb begin
    kind = bpc_pkg::KIND_NONE;
    for (int unsigned i = 0; i < NUM_BUTTONS; i++) begin
      if (evt[i].long_fire) begin
        kind = bpc_pkg::KIND_LONG;
      end else if (evt[i].short_fire) begin
        kind = bpc_pkg::KIND_SHORT;
      end
    end
  end

  // Flags and feedback counter
  always_comb begin
    hide_d  = hide_q ^ longs[0];
    auto_d  = auto_q ^ shorts[0];
    flash_d = (flash_q != '0) ? flash_q - {{(bpc_pkg::FlashW-1){1'b0}}, 1'b1} : flash_q;
    unique case (kind)
      bpc_pkg::KIND_SHORT: flash_d = bpc_pkg::FlashShort;
      bpc_pkg::KIND_LONG:  flash_d = bpc_pkg::FlashLong;
      default:             flash_d = flash_d;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hide_q  <= 1'b0;
      auto_q  <= 1'b0;
      flash_q <= '0;
    end else if (adv) begin
      hide_q  <= hide_d;
      auto_q  <= auto_d;
      flash_q <= flash_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {flash_d, kind, restart, auto_d, hide_d, longs, shorts};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  `BPC_ASSERT_IMPL(a_evt_excl, clk_i, rst_ni, adv, ((shorts & longs) == '0))
  `BPC_ASSERT_IMPL(a_kind_none, clk_i, rst_ni, adv,
                   ((kind == bpc_pkg::KIND_NONE) == ((shorts | longs) == '0)))
  `BPC_ASSERT(a_hide_toggle, clk_i, rst_ni, (adv && longs[0]) |=> (hide_q != $past(hide_q)))
  `BPC_ASSERT(a_long_flash, clk_i, rst_ni,
              (adv && (kind == bpc_pkg::KIND_LONG)) |=> (flash_q == bpc_pkg::FlashLong))

endmodule

`default_nettype wire

[design/bpc_lane.sv]
// ---------------------------------------------------------------------------
// bpc_lane
// Mode tracker and saturating hold counter of one button.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpc_lane (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         adv_i,     // tick is committed
  input  wire logic                         down_i,
  input  wire logic [bpc_pkg::CountW-1:0]   thresh_i,
  output bpc_pkg::bpc_evt_t                 evt_o
);

  bpc_pkg::bpc_mode_e              mode_q, mode_d, mode_eff;
  logic [bpc_pkg::CountW-1:0]      count_q, count_d, count_base, count_inc;
  logic                            long_fire;

  // Enter pressed with a fresh count when going down from idle
  always_comb begin
    mode_eff   = (mode_q == bpc_pkg::MODE_IDLE) ? bpc_pkg::MODE_PRESSED : mode_q;
    count_base = (mode_q == bpc_pkg::MODE_IDLE) ? '0 : count_q;
    count_inc  = (count_base == bpc_pkg::CountMax) ? count_base
                                                   : count_base + {{(bpc_pkg::CountW-1){1'b0}}, 1'b1};
    long_fire  = down_i && (mode_eff == bpc_pkg::MODE_PRESSED) && (count_inc > thresh_i);
  end

  // Next mode and count
  always_comb begin
    mode_d  = mode_q;
    count_d = count_q;
    if (down_i) begin
      count_d = count_inc;
      unique case (mode_eff)
        bpc_pkg::MODE_PRESSED: mode_d = long_fire ? bpc_pkg::MODE_LONG : bpc_pkg::MODE_PRESSED;
        bpc_pkg::MODE_LONG:    mode_d = bpc_pkg::MODE_HELD;
        bpc_pkg::MODE_HELD:    mode_d = bpc_pkg::MODE_HELD;
        default:               mode_d = bpc_pkg::MODE_IDLE;
      endcase
    end else begin
      mode_d  = bpc_pkg::MODE_IDLE;
      count_d = '0;
    end
  end

  assign evt_o.long_fire  = long_fire;
  assign evt_o.short_fire = !down_i && (mode_q == bpc_pkg::MODE_PRESSED);

  // Commit state once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= bpc_pkg::MODE_IDLE;
      count_q <= '0;
    end else if (adv_i) begin
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: button_press_classifier testbench
// Drives ticks of raw button levels into the slave stream and checks every
// result transfer against an in-bench press tracker. Covers the reset
// threshold, thresholds zero, one and the top of the 16-bit range, and
// random press gestures under several idle and stall mixes.
// ---------------------------------------------------------------------------

module tb;

  localparam int unsigned NumKeys    = 4;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainWait  = 6;

  // One result item, unpacked
  typedef struct {
    logic [3:0]                 shorts;
    logic [3:0]                 longs;
    logic                       hidden;
    logic                       zoom;
    logic                       restart;
    bpc_pkg::bpc_kind_e         kind;
    logic [bpc_pkg::FlashW-1:0] hold;
  } press_result_t;

  // -------------------------------------------------------------------------
  // Press tracker and result scoreboard
  // -------------------------------------------------------------------------
  class press_scoreboard;
    bpc_pkg::bpc_mode_e         mode [NumKeys];
    logic [bpc_pkg::CountW-1:0] count [NumKeys];
    logic                       hide_flag;
    logic                       zoom_flag;
    logic [bpc_pkg::FlashW-1:0] flash;
    logic [bpc_pkg::CountW-1:0] threshold;
    press_result_t              pending_results [$];
    int unsigned                errors;
    int unsigned                ticks_checked;
    int unsigned                shorts_seen;
    int unsigned                longs_seen;

    function new();
      for (int i = 0; i < NumKeys; i++) begin
        mode[i]  = bpc_pkg::MODE_IDLE;
        count[i] = '0;
      end
      hide_flag = 1'b0;
      zoom_flag = 1'b0;
      flash     = '0;
      threshold = bpc_pkg::ThreshReset;
      errors    = 0;
      ticks_checked = 0;
      shorts_seen   = 0;
      longs_seen    = 0;
    endfunction

    // Advance the tracker by one accepted tick and queue its result
    function void note_tick(logic [3:0] raw);
      press_result_t res;
      res.shorts  = '0;
      res.longs   = '0;
      res.restart = 1'b0;
      res.kind    = bpc_pkg::KIND_NONE;
      if (flash != 0) flash = flash - 1'b1;
      for (int i = 0; i < NumKeys; i++) begin
        if (raw[i]) begin
          if (mode[i] == bpc_pkg::MODE_IDLE) begin
            mode[i]  = bpc_pkg::MODE_PRESSED;
            count[i] = '0;
          end
          if (count[i] != bpc_pkg::CountMax) count[i] = count[i] + 1'b1;
          if (count[i] > threshold && mode[i] == bpc_pkg::MODE_PRESSED) begin
            mode[i]      = bpc_pkg::MODE_LONG;
            res.kind     = bpc_pkg::KIND_LONG;
            res.longs[i] = 1'b1;
            if (i == 0) hide_flag = ~hide_flag;
            if (i == 3) res.restart = 1'b1;
          end else if (mode[i] == bpc_pkg::MODE_LONG) begin
            mode[i] = bpc_pkg::MODE_HELD;
          end
        end else if (mode[i] != bpc_pkg::MODE_IDLE) begin
          if (mode[i] == bpc_pkg::MODE_PRESSED) begin
            res.kind      = bpc_pkg::KIND_SHORT;
            res.shorts[i] = 1'b1;
            if (i == 0) zoom_flag = ~zoom_flag;
            if (i == 3) res.restart = 1'b1;
          end
          mode[i]  = bpc_pkg::MODE_IDLE;
          count[i] = '0;
        end
      end
      if (res.kind == bpc_pkg::KIND_SHORT) flash = bpc_pkg::FlashShort;
      else if (res.kind == bpc_pkg::KIND_LONG) flash = bpc_pkg::FlashLong;
      res.hidden = hide_flag;
      res.zoom   = zoom_flag;
      res.hold   = flash;
      pending_results.push_back(res);
    endfunction

    function void report_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(logic [15:0] data);
      press_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual 0x%04h", $time, data);
        return;
      end
      want = pending_results.pop_front();
      ticks_checked++;
      report_field("short_events", want.shorts, data[3:0]);
      report_field("long_events", want.longs, data[7:4]);
      report_field("ui_hidden", want.hidden, data[8]);
      report_field("auto_zoom_on", want.zoom, data[9]);
      report_field("restart_render", want.restart, data[10]);
      report_field("feedback_kind", want.kind, data[12:11]);
      report_field("feedback_hold", want.hold, data[15:13]);
      shorts_seen += $countones(want.shorts);
      longs_seen  += $countones(want.longs);
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and block under test
  // -------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [3:0] buttons_raw, [7:4] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [3:0] short, [7:4] long, [8] hidden, [9] zoom,
                                    // [10] restart, [12:11] kind, [15:13] hold

  press_scoreboard board = new();
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles    = 0;
  logic [3:0]  levels    = '0;

  always #2 clk_i = ~clk_i;

  button_press_classifier #(
    .NUM_BUTTONS (NumKeys)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Stall the receiver at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Check each result transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               board.pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Driver tasks
  // -------------------------------------------------------------------------
  // Send one tick, with a random gap first, and hold until the transfer
  task automatic send_tick(input logic [3:0] raw);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, raw};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_tick(raw);
  endtask

  task automatic hold_keys(input logic [3:0] raw, input int unsigned n);
    for (int unsigned k = 0; k < n; k++) send_tick(raw);
  endtask

  // Stop sending and wait out every outstanding result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Write the long press threshold while the block is idle
  task automatic set_threshold(input logic [15:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.threshold = value;
  endtask

  // Random gestures: each button toggles now and then, with some noise ticks
  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input logic [15:0] thresh, input int unsigned n);
    logic [3:0] raw;
    set_threshold(thresh);
    idle_pct  = idle;
    stall_pct = stall;
    for (int unsigned k = 0; k < n; k++) begin
      if (k == n / 2) drain();
      if ($urandom_range(99) < 6) begin
        raw = 4'($urandom_range(15));
      end else begin
        for (int i = 0; i < NumKeys; i++)
          if ($urandom_range(thresh + 3) == 0) levels[i] = ~levels[i];
        raw = levels;
      end
      send_tick(raw);
    end
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset threshold: long on tick 21, then held, then silent release
    hold_keys(4'b0000, 1);
    hold_keys(4'b1111, 23);
    hold_keys(4'b0000, 1);

    // Threshold zero: long on the first tick down
    set_threshold(16'd0);
    hold_keys(4'b0101, 1);
    hold_keys(4'b1010, 2);
    hold_keys(4'b0000, 1);

    // Threshold one: one tick gives short, two give long
    set_threshold(16'd1);
    hold_keys(4'b1111, 1);
    hold_keys(4'b0000, 1);
    hold_keys(4'b1001, 2);
    hold_keys(4'b0110, 1);
    hold_keys(4'b0000, 3);

    // Top threshold: the count never exceeds it, release gives short
    set_threshold(16'hFFFF);
    hold_keys(4'b1111, 30);
    hold_keys(4'b0000, 1);

    // One below the top: a short hold still releases as short
    set_threshold(16'hFFFE);
    hold_keys(4'b1011, 25);
    hold_keys(4'b0000, 1);

    // Random gestures under several idle and stall mixes
    run_phase(0, 0, 16'($urandom_range(1, 10)), 215);
    run_phase(68, 0, 16'($urandom_range(1, 10)), 215);
    run_phase(0, 68, 16'($urandom_range(1, 10)), 215);
    run_phase(27, 27, 16'd1, 215);

    drain();
    if (board.pending_results.size() != 0) begin
      board.errors++;
      $display("%0t: %0d expected results never arrived", $time,
               board.pending_results.size());
    end
    $display("Checked %0d ticks with %0d short and %0d long events,", board.ticks_checked,
             board.shorts_seen, board.longs_seen);
    $display("thresholds 0 to 65535 and four idle/stall mixes.");
    if (board.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
